### rtl/pva_pkg.sv
// Shared types and constants of the polyphonic voice allocator.
// Holds the item structs, operation and status codes and the cell command bus.
// No dependencies.
package pva_pkg;

   // Fixed field widths and widest internal indexes over the parameter ranges
   localparam int LEVEL_W = 16;
   localparam int SUM_W   = 19;   // up to eight 16-bit levels
   localparam int VIDX_W  = 5;    // up to 32 voices
   localparam int IIDX_W  = 4;    // up to 16 instruments
   localparam int OIDX_W  = 3;    // up to 8 oscillators

   // Envelope state codes
   localparam logic [2:0] ENV_IDLE    = 3'd0;
   localparam logic [2:0] ENV_ATTACK  = 3'd1;
   localparam logic [2:0] ENV_RELEASE = 3'd4;

   localparam logic [3:0] COUNT_MAX = 4'd15;

   typedef enum logic [1:0] {
      OP_NOTE_ON    = 2'd0,
      OP_NOTE_OFF   = 2'd1,
      OP_ALL_OFF    = 2'd2,
      OP_ENV_REPORT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_NEW    = 2'd0,
      STAT_STOLEN = 2'd1,
      STAT_NONE   = 2'd2,
      STAT_DONE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_GRANT   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_REPORT  = 2'd3
   } cmd_kind_type;

   typedef enum logic [2:0] {
      FSM_IDLE   = 3'd0,
      FSM_SUM    = 3'd1,
      FSM_LAUNCH = 3'd2,
      FSM_SCAN   = 3'd3,
      FSM_APPLY  = 3'd4
   } fsm_type;

   typedef struct packed {
      op_type             op;
      logic [1:0]         instrument;
      logic [2:0]         voice_sel;
      logic [1:0]         osc_sel;
      logic [15:0]        pitch;
      logic [7:0]         velocity;
      logic [2:0]         env_state;
      logic [LEVEL_W-1:0] env_level;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [2:0] voice_out;
      logic [3:0] active_voices;
   } rsp_type;

   // Command broadcast from the controller to every voice cell
   typedef struct packed {
      cmd_kind_type       kind;
      logic               all_voices;
      logic [VIDX_W-1:0]  voice;
      logic [IIDX_W-1:0]  instrument;
      logic [OIDX_W-1:0]  osc;
      logic [15:0]        pitch;
      logic [7:0]         velocity;
      logic [2:0]         env_state;
      logic [LEVEL_W-1:0] env_level;
   } cmd_type;

   // Scan item handed from cell to cell during a note on
   typedef struct packed {
      logic              valid;
      logic              have;
      logic              fresh;
      logic [SUM_W-1:0]  best;
      logic [VIDX_W-1:0] chosen;
   } token_type;

endpackage

### rtl/poly_voice_allocator_core.sv
// Top level of the polyphonic voice allocator: controller, voice counts and
// the chain of voice cells. Depends on pva_pkg and pva_cell.
//
// One item is taken when start is high and busy is low; its single result shows on
// rsp_data for one cycle with rsp_strobe high and cannot be held off. Note off,
// all notes off, envelope reports and note ons for an invalid instrument go
// straight to the apply state. A note on for a valid instrument first registers
// every cell's level sum, then the candidate voice moves one cell per cycle down
// the chain, then the apply state applies the grant.
module poly_voice_allocator_core
   import pva_pkg::*;
#(
   parameter int NUM_INSTRUMENTS = 4,
   parameter int NUM_VOICES      = 8,
   parameter int NUM_OSCS        = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IW = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;

   fsm_type   state_ff;
   fsm_type   state_in;
   req_type   req_ff;
   token_type res_ff;
   logic [3:0] count_ff [NUM_INSTRUMENTS];
   logic      rsp_strobe_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;

   token_type                 chain [NUM_VOICES+1];
   logic [NUM_VOICES-1:0]     freed_vec;
   cmd_type                   cmd;

   logic       accept;
   logic       new_ins_ok;
   logic       ins_ok;
   logic       vsel_ok;
   logic       osc_ok;
   logic [IW-1:0] ins_idx;
   logic       freed_any;
   logic [3:0] count_cur;
   logic [3:0] count_in;

   assign accept     = start && !busy;
   assign busy       = (state_ff != FSM_IDLE);
   assign new_ins_ok = 32'(req_data.instrument) < NUM_INSTRUMENTS;
   assign ins_ok     = 32'(req_ff.instrument) < NUM_INSTRUMENTS;
   assign vsel_ok    = 32'(req_ff.voice_sel) < NUM_VOICES;
   assign osc_ok     = 32'(req_ff.osc_sel) < NUM_OSCS;
   assign ins_idx    = IW'(req_ff.instrument);
   assign freed_any  = |freed_vec;

   // Head of the chain: inject an empty candidate once the sums are registered
   always_comb begin
      chain[0]       = '0;
      chain[0].valid = (state_ff == FSM_LAUNCH);
   end

   // Voice cells
   for (genvar v = 0; v < NUM_VOICES; v++) begin : g_cell
      pva_cell #(
         .NUM_INSTRUMENTS (NUM_INSTRUMENTS),
         .NUM_OSCS        (NUM_OSCS),
         .CELL_INDEX      (v)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .token_in  (chain[v]),
         .token_out (chain[v+1]),
         .freed     (freed_vec[v])
      );
   end

   // Build the cell command; only the apply cycle writes state
   always_comb begin
      cmd            = '0;
      cmd.kind       = CMD_NONE;
      cmd.instrument = IIDX_W'(req_ff.instrument);
      cmd.osc        = OIDX_W'(req_ff.osc_sel);
      cmd.pitch      = req_ff.pitch;
      cmd.velocity   = req_ff.velocity;
      cmd.env_state  = req_ff.env_state;
      cmd.env_level  = req_ff.env_level;
      cmd.voice      = (req_ff.op == OP_NOTE_ON) ? res_ff.chosen
                                                 : VIDX_W'(req_ff.voice_sel);
      cmd.all_voices = (req_ff.op == OP_ALL_OFF);
      if (state_ff == FSM_APPLY) begin
         unique case (req_ff.op)
            OP_NOTE_ON: begin
               if (ins_ok && res_ff.have) cmd.kind = CMD_GRANT;
            end
            OP_NOTE_OFF: begin
               if (ins_ok && vsel_ok) cmd.kind = CMD_RELEASE;
            end
            OP_ALL_OFF: begin
               if (ins_ok) cmd.kind = CMD_RELEASE;
            end
            OP_ENV_REPORT: begin
               if (ins_ok && vsel_ok && osc_ok) cmd.kind = CMD_REPORT;
            end
         endcase
      end
   end

   // Active voice count and result of the item
   always_comb begin
      count_cur = ins_ok ? count_ff[ins_idx] : 4'd0;
      count_in  = count_cur;
      if ((cmd.kind == CMD_GRANT) && res_ff.fresh && (count_cur != COUNT_MAX)) begin
         count_in = count_cur + 4'd1;
      end
      if ((cmd.kind == CMD_REPORT) && freed_any && (count_cur != 4'd0)) begin
         count_in = count_cur - 4'd1;
      end
      rsp_in.active_voices = count_in;
      rsp_in.status        = STAT_DONE;
      rsp_in.voice_out     = req_ff.voice_sel;
      unique case (req_ff.op)
         OP_NOTE_ON: begin
            rsp_in.voice_out = 3'd0;
            rsp_in.status    = STAT_NONE;
            if (cmd.kind == CMD_GRANT) begin
               rsp_in.voice_out = res_ff.chosen[2:0];
               rsp_in.status    = res_ff.fresh ? STAT_NEW : STAT_STOLEN;
            end
         end
         OP_ALL_OFF: begin
            rsp_in.voice_out = 3'd0;
         end
         OP_NOTE_OFF, OP_ENV_REPORT: begin
         end
      endcase
   end

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = ((req_data.op == OP_NOTE_ON) && new_ins_ok) ? FSM_SUM
                                                                      : FSM_APPLY;
            end
         end
         FSM_SUM:    state_in = FSM_LAUNCH;
         FSM_LAUNCH: state_in = FSM_SCAN;
         FSM_SCAN: begin
            if (chain[NUM_VOICES].valid) state_in = FSM_APPLY;
         end
         FSM_APPLY:  state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Clear and capture the scan outcome, update counts and drive the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_INSTRUMENTS; i++) begin
            count_ff[i] <= 4'd0;
         end
      end else begin
         rsp_strobe_ff <= (state_ff == FSM_APPLY);
         if (accept) begin
            res_ff <= '0;
         end else if ((state_ff == FSM_SCAN) && chain[NUM_VOICES].valid) begin
            res_ff <= chain[NUM_VOICES];
         end
         if ((state_ff == FSM_APPLY) && ins_ok) begin
            count_ff[ins_idx] <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff <= '0;
      end else if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == FSM_APPLY) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // A result only follows an apply cycle
   a_strobe_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == FSM_APPLY))
      else $error("result strobe without apply cycle");

   // The scan candidate leaves the chain only while the sequencer waits for it
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain[NUM_VOICES].valid |-> (state_ff == FSM_SCAN))
      else $error("scan candidate outside scan state");

   // At most one voice is freed by a report
   a_one_freed: assert property (@(posedge clock) disable iff (reset)
      $onehot0(freed_vec))
      else $error("several voices freed at once");

endmodule

### rtl/pva_cell.sv
// One voice slot of the allocator: holds that voice's state for every instrument
// and takes part in the note-on scan by passing the candidate on to its neighbour.
// Depends on pva_pkg.
module pva_cell
   import pva_pkg::*;
#(
   parameter int NUM_INSTRUMENTS = 4,
   parameter int NUM_OSCS        = 4,
   parameter int CELL_INDEX      = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  token_type token_in,
   output token_type token_out,
   output logic      freed
);

   localparam int IW = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
   localparam int OW = $clog2(NUM_OSCS);

   logic                             gate_ff     [NUM_INSTRUMENTS];
   logic [2:0]                       penv_ff     [NUM_INSTRUMENTS];
   logic [NUM_OSCS-1:0][2:0]         st_ff       [NUM_INSTRUMENTS];
   logic [NUM_OSCS-1:0][LEVEL_W-1:0] lv_ff       [NUM_INSTRUMENTS];
   logic [15:0]                      pitch_ff    [NUM_INSTRUMENTS];
   logic [7:0]                       vel_ff      [NUM_INSTRUMENTS];
   logic [SUM_W-1:0]                 sum_ff;
   logic [SUM_W-1:0]                 sum_in;
   token_type                        token_ff;
   token_type                        token_fwd_in;

   logic [IW-1:0]                    ins_idx;
   logic [OW-1:0]                    osc_idx;
   logic [NUM_OSCS-1:0][2:0]         st_row;
   logic [NUM_OSCS-1:0][LEVEL_W-1:0] lv_row;
   logic [NUM_OSCS-1:0][2:0]         st_row_in;
   logic [NUM_OSCS-1:0][LEVEL_W-1:0] lv_row_in;
   logic                             gate_in;
   logic [2:0]                       penv_in;
   logic                             row_idle;
   logic                             others_idle;
   logic                             hit;
   logic                             upd;
   logic                             store_note;

   assign ins_idx = cmd.instrument[IW-1:0];
   assign osc_idx = cmd.osc[OW-1:0];
   assign st_row  = st_ff[ins_idx];
   assign lv_row  = lv_ff[ins_idx];
   assign hit     = cmd.all_voices || (cmd.voice == VIDX_W'(CELL_INDEX));

   // Level sum and idle flags of the addressed instrument's row
   always_comb begin
      sum_in      = '0;
      row_idle    = 1'b1;
      others_idle = 1'b1;
      for (int o = 0; o < NUM_OSCS; o++) begin
         sum_in = sum_in + SUM_W'(lv_row[o]);
         if (st_row[o] != ENV_IDLE) begin
            row_idle = 1'b0;
            if (OW'(o) != osc_idx) begin
               others_idle = 1'b0;
            end
         end
      end
   end

   // Scan step: take the voice if it is free, else keep the quieter candidate
   always_comb begin
      token_fwd_in = token_in;
      if (token_in.valid && !token_in.fresh && !gate_ff[ins_idx]) begin
         if (row_idle) begin
            token_fwd_in.have   = 1'b1;
            token_fwd_in.fresh  = 1'b1;
            token_fwd_in.chosen = VIDX_W'(CELL_INDEX);
         end else if (!token_in.have || (sum_ff < token_in.best)) begin
            token_fwd_in.have   = 1'b1;
            token_fwd_in.best   = sum_ff;
            token_fwd_in.chosen = VIDX_W'(CELL_INDEX);
         end
      end
   end

   // Row updates for grant, release and envelope report
   always_comb begin
      st_row_in  = st_row;
      lv_row_in  = lv_row;
      gate_in    = gate_ff[ins_idx];
      penv_in    = penv_ff[ins_idx];
      freed      = 1'b0;
      upd        = 1'b0;
      store_note = 1'b0;
      if (hit) begin
         unique case (cmd.kind)
            CMD_NONE: begin
            end
            CMD_GRANT: begin
               upd        = 1'b1;
               store_note = 1'b1;
               for (int o = 0; o < NUM_OSCS; o++) begin
                  st_row_in[o] = ENV_ATTACK;
                  lv_row_in[o] = '0;
               end
               gate_in = 1'b1;
               penv_in = ENV_ATTACK;
            end
            CMD_RELEASE: begin
               upd = 1'b1;
               for (int o = 0; o < NUM_OSCS; o++) begin
                  if (st_row[o] != ENV_IDLE) begin
                     st_row_in[o] = ENV_RELEASE;
                  end
               end
               gate_in = 1'b0;
               if (penv_ff[ins_idx] != ENV_IDLE) begin
                  penv_in = ENV_RELEASE;
               end
            end
            CMD_REPORT: begin
               upd                = 1'b1;
               st_row_in[osc_idx] = cmd.env_state;
               lv_row_in[osc_idx] = cmd.env_level;
               freed = !row_idle && others_idle && (cmd.env_state == ENV_IDLE);
               if (freed) begin
                  gate_in = 1'b0;
               end
            end
         endcase
      end
   end

   // Hold voice state, register the sum and hand the scan item on
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_INSTRUMENTS; i++) begin
            gate_ff[i]  <= 1'b0;
            penv_ff[i]  <= ENV_IDLE;
            st_ff[i]    <= '0;
            lv_ff[i]    <= '0;
            pitch_ff[i] <= '0;
            vel_ff[i]   <= '0;
         end
         sum_ff   <= '0;
         token_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         token_ff <= token_fwd_in;
         if (upd) begin
            gate_ff[ins_idx] <= gate_in;
            penv_ff[ins_idx] <= penv_in;
            st_ff[ins_idx]   <= st_row_in;
            lv_ff[ins_idx]   <= lv_row_in;
         end
         if (store_note) begin
            pitch_ff[ins_idx] <= cmd.pitch;
            vel_ff[ins_idx]   <= cmd.velocity;
         end
      end
   end

   assign token_out = token_ff;

endmodule

### bench/tb_poly_voice_allocator_core.sv
// Self-checking bench for poly_voice_allocator_core: directed and random note and
// envelope items, each result compared with a voice-allocation predictor.
// Depends on pva_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_poly_voice_allocator_core
   import pva_pkg::*;
();

   localparam int NUM_INSTRUMENTS = 4;
   localparam int NUM_VOICES      = 8;
   localparam int NUM_OSCS        = 4;
   localparam int RANDOM_ITEMS    = 1700;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 2 * NUM_VOICES + 8;
   localparam int REPORT_LIMIT    = 10;

   // Mirror of the allocator state plus the queue of outstanding results
   class voice_scoreboard;
      bit         gate [NUM_INSTRUMENTS][NUM_VOICES];
      bit [2:0]   pitch_eg [NUM_INSTRUMENTS][NUM_VOICES];
      bit [2:0]   osc_state [NUM_INSTRUMENTS][NUM_VOICES][NUM_OSCS];
      bit [15:0]  osc_level [NUM_INSTRUMENTS][NUM_VOICES][NUM_OSCS];
      bit [15:0]  note_pitch [NUM_INSTRUMENTS][NUM_VOICES];
      bit [7:0]   note_vel [NUM_INSTRUMENTS][NUM_VOICES];
      bit [3:0]   active [NUM_INSTRUMENTS];
      rsp_type    expected_q[$];
      int         mismatches;

      function bit voice_idle(int ins, int v);
         for (int o = 0; o < NUM_OSCS; o++)
            if (osc_state[ins][v][o] != ENV_IDLE) return 1'b0;
         return 1'b1;
      endfunction

      // Drop the gate and move every sounding envelope to release
      function void release_voice(int ins, int v);
         for (int o = 0; o < NUM_OSCS; o++)
            if (osc_state[ins][v][o] != ENV_IDLE) osc_state[ins][v][o] = ENV_RELEASE;
         gate[ins][v] = 1'b0;
         if (pitch_eg[ins][v] != ENV_IDLE) pitch_eg[ins][v] = ENV_RELEASE;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Advance the mirror by one accepted item and queue its result
      function void note_item(req_type item);
         rsp_type want;
         int      ins, vsel, osel, best, sum, chosen;
         bit      ins_ok, found, fresh, was_idle;
         ins    = int'(item.instrument);
         vsel   = int'(item.voice_sel);
         osel   = int'(item.osc_sel);
         ins_ok = ins < NUM_INSTRUMENTS;
         want.status    = STAT_DONE;
         want.voice_out = item.voice_sel;
         case (item.op)
            OP_NOTE_ON: begin
               want.status    = STAT_NONE;
               want.voice_out = '0;
               if (ins_ok) begin
                  found  = 1'b0;
                  fresh  = 1'b0;
                  best   = 0;
                  chosen = 0;
                  // first idle voice wins; else the quietest released voice
                  for (int v = 0; v < NUM_VOICES && !fresh; v++) begin
                     if (!gate[ins][v]) begin
                        if (voice_idle(ins, v)) begin
                           chosen = v;
                           found  = 1'b1;
                           fresh  = 1'b1;
                        end else begin
                           sum = 0;
                           for (int o = 0; o < NUM_OSCS; o++)
                              sum += int'(osc_level[ins][v][o]);
                           if (!found || sum < best) begin
                              best   = sum;
                              chosen = v;
                              found  = 1'b1;
                           end
                        end
                     end
                  end
                  if (found) begin
                     for (int o = 0; o < NUM_OSCS; o++) begin
                        osc_state[ins][chosen][o] = ENV_ATTACK;
                        osc_level[ins][chosen][o] = '0;
                     end
                     gate[ins][chosen]       = 1'b1;
                     pitch_eg[ins][chosen]   = ENV_ATTACK;
                     note_pitch[ins][chosen] = item.pitch;
                     note_vel[ins][chosen]   = item.velocity;
                     if (fresh && active[ins] != COUNT_MAX) active[ins]++;
                     want.status    = fresh ? STAT_NEW : STAT_STOLEN;
                     want.voice_out = 3'(chosen);
                  end
               end
            end
            OP_NOTE_OFF: begin
               if (ins_ok && vsel < NUM_VOICES) release_voice(ins, vsel);
            end
            OP_ALL_OFF: begin
               want.voice_out = '0;
               if (ins_ok)
                  for (int v = 0; v < NUM_VOICES; v++) release_voice(ins, v);
            end
            default: begin
               if (ins_ok && vsel < NUM_VOICES && osel < NUM_OSCS) begin
                  was_idle = voice_idle(ins, vsel);
                  osc_state[ins][vsel][osel] = item.env_state;
                  osc_level[ins][vsel][osel] = item.env_level;
                  // free the voice when its last envelope has died away
                  if (!was_idle && voice_idle(ins, vsel)) begin
                     if (active[ins] != 0) active[ins]--;
                     gate[ins][vsel] = 1'b0;
                  end
               end
            end
         endcase
         want.active_voices = ins_ok ? active[ins] : '0;
         expected_q.push_back(want);
      endfunction

      // Compare one result with the oldest outstanding expectation
      function void check_item(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result status=%0d voice=%0d active=%0d",
                        $realtime, got.status, got.voice_out, got.active_voices);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status || got.voice_out !== want.voice_out ||
             got.active_voices !== want.active_voices) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: mismatch exp status=%0d voice=%0d active=%0d, got %0d %0d %0d",
                        $realtime, want.status, want.voice_out, want.active_voices,
                        got.status, got.voice_out, got.active_voices);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   voice_scoreboard sb = new;
   int max_gap;
   int cycles;

   poly_voice_allocator_core #(
      .NUM_INSTRUMENTS(NUM_INSTRUMENTS),
      .NUM_VOICES     (NUM_VOICES),
      .NUM_OSCS       (NUM_OSCS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Check every strobed result
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_item(rsp_data);
   end

   function automatic req_type make_item(op_type op, int ins, int voice, int osc,
                                         logic [15:0] pitch, logic [7:0] vel,
                                         logic [2:0] st, logic [15:0] lev);
      req_type item;
      item.op         = op;
      item.instrument = 2'(ins);
      item.voice_sel  = 3'(voice);
      item.osc_sel    = 2'(osc);
      item.pitch      = pitch;
      item.velocity   = vel;
      item.env_state  = st;
      item.env_level  = lev;
      return item;
   endfunction

   // Random item, mostly aimed at gated voices and sounding envelopes
   function automatic req_type random_item();
      req_type     item;
      logic [63:0] raw;
      int          pick, ins, sel, r;
      int          gated[$];
      int          sounding[$];
      raw  = {$urandom, $urandom};
      item = req_type'(raw[$bits(req_type)-1:0]);
      ins  = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(0, NUM_INSTRUMENTS - 1);
      item.instrument = 2'(ins);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         item.op = OP_NOTE_ON;
      end else if (pick < 50) begin
         item.op = OP_NOTE_OFF;
         for (int v = 0; v < NUM_VOICES; v++)
            if (sb.gate[ins][v]) gated.push_back(v);
         if (gated.size() != 0 && $urandom_range(0, 9) < 7)
            item.voice_sel = 3'(gated[$urandom_range(0, gated.size() - 1)]);
      end else if (pick < 54) begin
         item.op = OP_ALL_OFF;
      end else begin
         item.op = OP_ENV_REPORT;
         for (int i = 0; i < NUM_INSTRUMENTS; i++)
            for (int v = 0; v < NUM_VOICES; v++)
               for (int o = 0; o < NUM_OSCS; o++)
                  if (sb.osc_state[i][v][o] != ENV_IDLE)
                     sounding.push_back((i * NUM_VOICES + v) * NUM_OSCS + o);
         if (sounding.size() != 0 && $urandom_range(0, 9) < 8) begin
            sel = sounding[$urandom_range(0, sounding.size() - 1)];
            item.osc_sel    = 2'(sel % NUM_OSCS);
            item.voice_sel  = 3'((sel / NUM_OSCS) % NUM_VOICES);
            item.instrument = 2'(sel / (NUM_OSCS * NUM_VOICES));
         end
         r = $urandom_range(0, 3);
         if (r < 2) item.env_state = ENV_IDLE;
         else if (r == 2) item.env_state = ENV_RELEASE;
         // small levels make equal sums, and so ties in the steal scan
         r = $urandom_range(0, 9);
         if (r < 2) item.env_level = 16'($urandom_range(0, 3));
         else if (r == 2) item.env_level = 16'hFFFF;
      end
      return item;
   endfunction

   // Present one item after a random gap and hold it until accepted
   task automatic send_item(input req_type item);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = item;
      start    = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_item(item);
      @(negedge clock);
   endtask

   // Hold off until every outstanding result has come back
   task automatic wait_drained();
      start = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      int k;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      max_gap  = 5;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes of pitch and velocity on the top instrument
      send_item(make_item(OP_NOTE_ON, 3, 0, 0, 16'hFFFF, 8'hFF, ENV_IDLE, 16'h0000));
      send_item(make_item(OP_NOTE_ON, 3, 7, 3, 16'h0000, 8'h00, 3'd7, 16'hFFFF));
      // fill every voice, then one more finds none
      for (k = 0; k < NUM_VOICES + 1; k++)
         send_item(make_item(OP_NOTE_ON, 1, k, 0, 16'h1000 + 16'(k), 8'h40 + 8'(k),
                             ENV_IDLE, 16'h0000));
      // release all, raise voice 0 so the tie among the rest goes to voice 1
      send_item(make_item(OP_ALL_OFF, 1, 5, 2, 16'h5555, 8'hAA, ENV_ATTACK, 16'h00FF));
      send_item(make_item(OP_ENV_REPORT, 1, 0, 3, 16'h0000, 8'h00, ENV_RELEASE, 16'hFFFF));
      send_item(make_item(OP_NOTE_ON, 1, 0, 0, 16'h2222, 8'h22, ENV_IDLE, 16'h0000));
      // let voice 1 die away envelope by envelope until it is freed
      send_item(make_item(OP_NOTE_OFF, 1, 1, 0, 16'h0000, 8'h00, ENV_IDLE, 16'h0000));
      for (k = 0; k < NUM_OSCS; k++)
         send_item(make_item(OP_ENV_REPORT, 1, 1, k, 16'h0000, 8'h00, ENV_IDLE, 16'h0000));
      send_item(make_item(OP_NOTE_ON, 1, 0, 0, 16'h3333, 8'h33, ENV_IDLE, 16'h0000));
      // wake an idle voice by report, then free it with the count already at zero
      send_item(make_item(OP_ENV_REPORT, 2, 0, 2, 16'h0000, 8'h00, 3'd7, 16'h1234));
      send_item(make_item(OP_ENV_REPORT, 2, 0, 2, 16'h0000, 8'h00, ENV_IDLE, 16'h0000));
      // note off on a silent voice, all notes off on a silent instrument
      send_item(make_item(OP_NOTE_OFF, 0, 5, 1, 16'hFFFF, 8'hFF, 3'd7, 16'hFFFF));
      send_item(make_item(OP_ALL_OFF, 0, 7, 3, 16'h0000, 8'h00, ENV_IDLE, 16'h0000));
      wait_drained();

      // random part in stretches with and without gaps
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 100 == 0) max_gap = ($urandom_range(0, 2) == 0) ? 0 : 5;
         if ($urandom_range(0, 59) == 0) wait_drained();
         send_item(random_item());
      end
      start = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
